@@ hw/rtl/p2c_pkg.sv @@
// p2c_pkg: shared types and constants for the planar to chunky converter.
// No dependencies; used by the lane, merge and top-level modules of the block.

package p2c_pkg;

  localparam int NumPlanes   = 5;   // plane inputs, also the saturation depth
  localparam int NumPixels   = 16;  // pixels covered by one plane word
  localparam int NibbleDepth = 4;   // deepest format that packs two pixels a byte
  localparam int CntW        = $clog2(NumPixels + 1);
  localparam int DepthW      = 3;
  localparam int CfgIdxW     = 2;
  localparam int CfgDataW    = 8;

  localparam logic [7:0] TextMark = 8'hC0;

  typedef logic [NumPlanes-1:0] color_t;
  typedef logic [7:0]           pix_byte_t;
  typedef logic [15:0]          plane_word_t;

  typedef enum logic [CfgIdxW-1:0] {
    CfgBitDepth = 2'd0,
    CfgTextMode = 2'd1
  } cfg_idx_e;

  // output format selection shared by the lanes and the merge stage
  typedef struct packed {
    logic              chunky;  // one pixel per byte
    logic              text;    // mark nonzero colours
    logic [DepthW-1:0] planes;  // planes used, saturated
  } mode_t;

endpackage

@@ hw/rtl/p2c_lane.sv @@
// p2c_lane: colour of one pixel from its column of plane bits.
// Depends on p2c_pkg.

module p2c_lane (
  input  p2c_pkg::color_t               col_i,
  input  logic [p2c_pkg::DepthW-1:0]    planes_i,
  output p2c_pkg::color_t               color_o
);

  always_comb begin
    for (int p = 0; p < p2c_pkg::NumPlanes; p++) begin
      color_o[p] = col_i[p] && (p2c_pkg::DepthW'(p) < planes_i);
    end
  end

endmodule

@@ hw/rtl/p2c_merge.sv @@
// p2c_merge: turns the sixteen lane colours into output bytes and a beat count.
// Depends on p2c_pkg.

module p2c_merge (
  input  p2c_pkg::color_t    color_i [p2c_pkg::NumPixels],
  input  p2c_pkg::mode_t     mode_i,
  output p2c_pkg::pix_byte_t bytes_o [p2c_pkg::NumPixels],
  output logic [p2c_pkg::CntW-1:0] count_o
);

  localparam int Half = p2c_pkg::NumPixels / 2;

  always_comb begin
    for (int i = 0; i < p2c_pkg::NumPixels; i++) begin
      bytes_o[i] = '0;
    end
    if (mode_i.chunky) begin
      count_o = p2c_pkg::CntW'(p2c_pkg::NumPixels);
      for (int i = 0; i < p2c_pkg::NumPixels; i++) begin
        bytes_o[i] = 8'(color_i[i]);
        if (mode_i.text && (color_i[i] != '0)) begin
          bytes_o[i] = bytes_o[i] | p2c_pkg::TextMark;
        end
      end
    end else begin
      count_o = p2c_pkg::CntW'(Half);
      // earlier pixel in the high nibble
      for (int i = 0; i < Half; i++) begin
        bytes_o[i] = {color_i[2*i][3:0], color_i[2*i+1][3:0]};
      end
    end
  end

endmodule

@@ hw/rtl/planar_to_chunky_converter_unit.sv @@
// planar_to_chunky_converter_unit: top level, input buffer, lanes and byte serialiser.
// Depends on p2c_pkg, p2c_lane and p2c_merge.
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+--------------------------------
//  in      | in        | in_valid_i/in_stall_o | plane_word_0_i .. plane_word_4_i
//  out     | out       | out_valid_o/out_stall_i | pixel_byte_o, last_byte_o
//  cfg     | in        | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//
// Each item gives 16 output beats in one-pixel-per-byte formats and 8 in the packed
// format; the serialiser sends one byte a cycle unless stalled, which sets the rate.
// An item passes the input buffer, then the serialiser registers; one item
// is buffered while the previous one is still being sent, so beats run back to back.
// Reset clears the buffer and serialiser and sets depth 4, text mode off.
// A stalled output holds its byte; the input stalls only when the buffer is full.

module planar_to_chunky_converter_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  p2c_pkg::plane_word_t           plane_word_0_i,
  input  p2c_pkg::plane_word_t           plane_word_1_i,
  input  p2c_pkg::plane_word_t           plane_word_2_i,
  input  p2c_pkg::plane_word_t           plane_word_3_i,
  input  p2c_pkg::plane_word_t           plane_word_4_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [7:0]                     pixel_byte_o,
  output logic                           last_byte_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [p2c_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [p2c_pkg::CfgDataW-1:0]   cfg_data_i
);

  logic [p2c_pkg::DepthW-1:0] bit_depth_q;
  logic                       text_mode_q;

  logic                 pend_valid_q;
  p2c_pkg::plane_word_t pend_q  [p2c_pkg::NumPlanes];

  p2c_pkg::pix_byte_t          bytes_q [p2c_pkg::NumPixels];
  p2c_pkg::pix_byte_t          bytes_d [p2c_pkg::NumPixels];
  logic [p2c_pkg::CntW-1:0]    rem_q, rem_d;

  p2c_pkg::mode_t              mode;
  p2c_pkg::color_t             color   [p2c_pkg::NumPixels];
  p2c_pkg::pix_byte_t          merged  [p2c_pkg::NumPixels];
  logic [p2c_pkg::CntW-1:0]    merged_cnt;

  logic in_acc, out_acc, load;

  // configuration
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bit_depth_q <= p2c_pkg::DepthW'(p2c_pkg::NibbleDepth);
      text_mode_q <= 1'b0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        p2c_pkg::CfgBitDepth: bit_depth_q <= cfg_data_i[p2c_pkg::DepthW-1:0];
        p2c_pkg::CfgTextMode: text_mode_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    mode.text   = text_mode_q;
    mode.chunky = text_mode_q || (bit_depth_q > p2c_pkg::DepthW'(p2c_pkg::NibbleDepth));
    mode.planes = (bit_depth_q > p2c_pkg::DepthW'(p2c_pkg::NumPlanes))
                ? p2c_pkg::DepthW'(p2c_pkg::NumPlanes) : bit_depth_q;
  end

  // handshakes
  assign out_valid_o = (rem_q != '0);
  assign last_byte_o = (rem_q == p2c_pkg::CntW'(1));
  assign out_acc     = out_valid_o && !out_stall_i;
  assign load        = pend_valid_q && (!out_valid_o || (out_acc && last_byte_o));
  assign in_stall_o  = pend_valid_q && !load;
  assign in_acc      = in_valid_i && !in_stall_o;

  // input buffer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_valid_q <= 1'b0;
    end else if (in_acc) begin
      pend_valid_q <= 1'b1;
    end else if (load) begin
      pend_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      pend_q[0] <= plane_word_0_i;
      pend_q[1] <= plane_word_1_i;
      pend_q[2] <= plane_word_2_i;
      pend_q[3] <= plane_word_3_i;
      pend_q[4] <= plane_word_4_i;
    end
  end

  // one lane per pixel; pixel k reads bit 15-k of every plane
  for (genvar k = 0; k < p2c_pkg::NumPixels; k++) begin : g_lane
    p2c_pkg::color_t col;
    for (genvar p = 0; p < p2c_pkg::NumPlanes; p++) begin : g_col
      assign col[p] = pend_q[p][p2c_pkg::NumPixels-1-k];
    end
    p2c_lane u_lane (
      .col_i    (col),
      .planes_i (mode.planes),
      .color_o  (color[k])
    );
  end

  p2c_merge u_merge (
    .color_i (color),
    .mode_i  (mode),
    .bytes_o (merged),
    .count_o (merged_cnt)
  );

  // serialiser: byte 0 is on the port, shift down each beat
  always_comb begin
    bytes_d = bytes_q;
    rem_d   = rem_q;
    if (load) begin
      bytes_d = merged;
      rem_d   = merged_cnt;
    end else if (out_acc) begin
      for (int i = 0; i < p2c_pkg::NumPixels - 1; i++) begin
        bytes_d[i] = bytes_q[i+1];
      end
      bytes_d[p2c_pkg::NumPixels-1] = '0;
      rem_d = rem_q - p2c_pkg::CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q <= '0;
    end else begin
      rem_q <= rem_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bytes_q <= bytes_d;
  end

  assign pixel_byte_o = bytes_q[0];

endmodule

@@ hw/rtl/p2c_checker.sv @@
// p2c_checker: port-level assertions for the converter, bound to the top level.
// Depends only on the ports of planar_to_chunky_converter_unit.

module p2c_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_stall_o,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [7:0] pixel_byte_o,
  input logic       last_byte_o
);

  // a stalled output beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(pixel_byte_o)
      && $stable(last_byte_o))
    else $error("output beat changed while stalled");

  // a burst runs without gaps up to its last byte
  a_burst: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !last_byte_o |=> out_valid_o)
    else $error("burst broke before last byte");

  // an item taken while the output is idle shows up once it has passed the input buffer and the serialiser registers
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && !out_valid_o |-> ##2 out_valid_o)
    else $error("no output after input beat");

  // the input only starts stalling once the buffer has just been filled
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(in_stall_o) |-> $past(in_valid_i && !in_stall_o))
    else $error("input stall without a buffered beat");

endmodule

bind planar_to_chunky_converter_unit p2c_checker u_p2c_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_stall_o   (in_stall_o),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .pixel_byte_o (pixel_byte_o),
  .last_byte_o  (last_byte_o)
);
